FILE: sv/fpa_pkg.sv
// Shared types, codes and helpers for the fixed-point ALU pipeline.
// No dependencies; every other file of the block imports this package.
package fpa_pkg;

  localparam int FRAC_BITS = 8;
  localparam int DATA_W    = 32;
  localparam int NUM_W     = DATA_W + FRAC_BITS;  // dividend width, one divider stage per bit
  localparam int MAG_W     = 2 * DATA_W;          // wide magnitude for saturation checks

  localparam logic [MAG_W-1:0] POS_LIM = {{(MAG_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (DATA_W-1);
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_MAX      = 4'd4,
    ACT_MIN      = 4'd5,
    ACT_INC      = 4'd6,
    ACT_DEC      = 4'd7,
    ACT_FROM_INT = 4'd8,
    ACT_TO_INT   = 4'd9
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  // Sideband that travels with each word down the pipeline
  typedef struct packed {
    logic [3:0]        action;
    logic [DATA_W-1:0] res;
    status_e           st;
    logic              gt;
    logic              lt;
    logic              eq;
    logic              neg;
    logic [DATA_W-1:0] mb;
  } side_t;

  // Divider working state: partial remainder and dividend/quotient shifter
  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [NUM_W-1:0]  nq;
  } div_t;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              ovf;
  } sat_t;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Signed value from sign and magnitude, saturated to DATA_W bits
  function automatic sat_t from_mag(input logic neg, input logic [MAG_W-1:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    r.res = neg ? (~mag[DATA_W-1:0] + 1'b1) : mag[DATA_W-1:0];
    if (!neg && (mag > POS_LIM)) begin
      r.ovf = 1'b1;
      r.res = SAT_MAX;
    end else if (neg && (mag > NEG_LIM)) begin
      r.ovf = 1'b1;
      r.res = SAT_MIN;
    end
    return r;
  endfunction

  // Saturate a sum carrying two guard bits
  function automatic sat_t sat_sum(input logic [DATA_W+1:0] v);
    sat_t r;
    r.ovf = !((v[DATA_W+1] == v[DATA_W]) && (v[DATA_W] == v[DATA_W-1]));
    r.res = r.ovf ? (v[DATA_W+1] ? SAT_MIN : SAT_MAX) : v[DATA_W-1:0];
    return r;
  endfunction

endpackage

FILE: sv/fpa_front.sv
// Front of the ALU pipeline: input register, simple operations, multiply and
// multiply rounding (three stages). Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [3:0]               action_i,
  input  logic signed [DATA_W-1:0] operand_a_i,
  input  logic signed [DATA_W-1:0] operand_b_i,
  output logic                     valid_o,
  output side_t                    side_o,
  output div_t                     div_o
);

  // stage A: registered inputs
  logic                     vld_a_q;
  logic [3:0]               act_a_q;
  logic signed [DATA_W-1:0] a_a_q;
  logic signed [DATA_W-1:0] b_a_q;

  // stage B: simple results and raw product
  logic              vld_b_q;
  side_t             side_b_d, side_b_q;
  logic [MAG_W-1:0]  prod_b_d, prod_b_q;
  logic [DATA_W-1:0] ma_b_q;

  // stage C
  logic              vld_c_q;
  side_t             side_c_d, side_c_q;
  div_t              div_c_d, div_c_q;

  logic [DATA_W-1:0] ma, mb;
  logic [DATA_W+1:0] a_ext, b_ext;
  sat_t              sr;
  logic [MAG_W-1:0]  prod_rnd;
  sat_t              mr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= valid_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_a_q  <= action_i;
      a_a_q    <= operand_a_i;
      b_a_q    <= operand_b_i;
      side_b_q <= side_b_d;
      prod_b_q <= prod_b_d;
      ma_b_q   <= ma;
      side_c_q <= side_c_d;
      div_c_q  <= div_c_d;
    end
  end

  always_comb begin
    ma    = magnitude(a_a_q);
    mb    = magnitude(b_a_q);
    a_ext = {{2{a_a_q[DATA_W-1]}}, a_a_q};
    b_ext = {{2{b_a_q[DATA_W-1]}}, b_a_q};
    sr    = '0;
    side_b_d        = '0;
    side_b_d.action = act_a_q;
    side_b_d.gt     = a_a_q > b_a_q;
    side_b_d.lt     = a_a_q < b_a_q;
    side_b_d.eq     = a_a_q == b_a_q;
    side_b_d.neg    = a_a_q[DATA_W-1] ^ b_a_q[DATA_W-1];
    side_b_d.mb     = mb;
    side_b_d.st     = ST_OK;
    prod_b_d        = MAG_W'(ma) * MAG_W'(mb);
    unique case (act_a_q)
      ACT_ADD:      sr = sat_sum(a_ext + b_ext);
      ACT_SUB:      sr = sat_sum(a_ext - b_ext);
      ACT_INC:      sr = sat_sum(a_ext + (DATA_W+2)'(1));
      ACT_DEC:      sr = sat_sum(a_ext - (DATA_W+2)'(1));
      ACT_MAX:      sr.res = side_b_d.gt ? a_a_q : b_a_q;
      ACT_MIN:      sr.res = side_b_d.lt ? a_a_q : b_a_q;
      ACT_FROM_INT: sr = from_mag(a_a_q[DATA_W-1], MAG_W'(ma) << FRAC_BITS);
      ACT_TO_INT:   sr = from_mag(a_a_q[DATA_W-1], MAG_W'(ma >> FRAC_BITS));
      default:      sr = '0;
    endcase
    side_b_d.res = sr.res;
    if (sr.ovf) begin
      side_b_d.st = ST_OVF;
    end
  end

  // round the product to nearest, ties away from zero, on the magnitude
  always_comb begin
    prod_rnd = (prod_b_q + (MAG_W'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
    mr       = from_mag(side_b_q.neg, prod_rnd);
    side_c_d = side_b_q;
    if (side_b_q.action == ACT_MUL) begin
      side_c_d.res = mr.res;
      side_c_d.st  = mr.ovf ? ST_OVF : ST_OK;
    end
    div_c_d.rem = '0;
    div_c_d.nq  = {ma_b_q, {FRAC_BITS{1'b0}}};
  end

  assign valid_o = vld_c_q;
  assign side_o  = side_c_q;
  assign div_o   = div_c_q;

endmodule

FILE: sv/fpa_div_step.sv
// One restoring-division stage: develops one quotient bit and carries the
// sideband along. Depends on fpa_pkg.
module fpa_div_step import fpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  side_t side_i,
  input  div_t  div_i,
  output logic  valid_o,
  output side_t side_o,
  output div_t  div_o
);

  logic              vld_q;
  side_t             side_q;
  div_t              div_d, div_q;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {div_i.rem, div_i.nq[NUM_W-1]};
    diff  = trial - {1'b0, side_i.mb};
    ge    = trial >= {1'b0, side_i.mb};
    // remainder stays below the divisor, so DATA_W bits hold it
    div_d.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    div_d.nq  = {div_i.nq[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      div_q  <= div_d;
    end
  end

  assign valid_o = vld_q;
  assign side_o  = side_q;
  assign div_o   = div_q;

endmodule

FILE: sv/fpa_back.sv
// Back of the ALU pipeline: quotient rounding, divide-by-zero handling and
// the output register. Depends on fpa_pkg.
module fpa_back import fpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  side_t             side_i,
  input  div_t              div_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] res_o,
  output logic              gt_o,
  output logic              lt_o,
  output logic              eq_o,
  output status_e           st_o
);

  logic              vld_q;
  logic [DATA_W-1:0] res_d, res_q;
  status_e           st_d, st_q;
  logic              gt_q, lt_q, eq_q;
  logic              round_up;
  logic [NUM_W:0]    quot;
  sat_t              qr;

  always_comb begin
    // round half away from zero: bump when twice the remainder reaches the divisor
    round_up = {div_i.rem, 1'b0} >= {1'b0, side_i.mb};
    quot     = {1'b0, div_i.nq} + (NUM_W+1)'(round_up);
    qr       = from_mag(side_i.neg, MAG_W'(quot));
    res_d    = side_i.res;
    st_d     = side_i.st;
    if (side_i.action == ACT_DIV) begin
      if (side_i.mb == '0) begin
        res_d = '0;
        st_d  = ST_DIV0;
      end else begin
        res_d = qr.res;
        st_d  = qr.ovf ? ST_OVF : ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      st_q  <= st_d;
      gt_q  <= side_i.gt;
      lt_q  <= side_i.lt;
      eq_q  <= side_i.eq;
    end
  end

  assign valid_o = vld_q;
  assign res_o   = res_q;
  assign st_o    = st_q;
  assign gt_o    = gt_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

FILE: sv/fixed_point_alu_top.sv
// At Q24.8 the pipeline has three front stages, one divider stage per
// dividend bit and one output stage. Throughput: one word per cycle; the
// whole pipeline holds while the output register is full and stalled.
// Reset clears all valid bits; no data is reset.
// Depends on fpa_pkg, fpa_front, fpa_div_step, fpa_back.
module fixed_point_alu_top import fpa_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [3:0]               action_i,
  input  logic signed [DATA_W-1:0] operand_a_i,
  input  logic signed [DATA_W-1:0] operand_b_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [DATA_W-1:0] result_o,
  output logic                     greater_o,
  output logic                     less_o,
  output logic                     equal_o,
  output logic [1:0]               status_o
);

  logic    en;
  logic    vld_s  [NUM_W+1];
  side_t   side_s [NUM_W+1];
  div_t    div_s  [NUM_W+1];
  logic [DATA_W-1:0] res;
  status_e st;

  // advance everything unless a finished word is held at the output
  assign en      = !valid_o || !stall_i;
  assign stall_o = !en;

  fpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (valid_i),
    .action_i    (action_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (vld_s[0]),
    .side_o      (side_s[0]),
    .div_o       (div_s[0])
  );

  for (genvar k = 0; k < NUM_W; k++) begin : g_div
    fpa_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_s[k]),
      .side_i  (side_s[k]),
      .div_i   (div_s[k]),
      .valid_o (vld_s[k+1]),
      .side_o  (side_s[k+1]),
      .div_o   (div_s[k+1])
    );
  end

  fpa_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vld_s[NUM_W]),
    .side_i  (side_s[NUM_W]),
    .div_i   (div_s[NUM_W]),
    .valid_o (valid_o),
    .res_o   (res),
    .gt_o    (greater_o),
    .lt_o    (less_o),
    .eq_o    (equal_o),
    .st_o    (st)
  );

  assign result_o = $signed(res);
  assign status_o = st;

endmodule

FILE: tb/sv/fixed_point_alu_top_test.sv
`timescale 1ns / 100ps
// Self-checking bench for fixed_point_alu_top: directed corner table, then random words.
// Depends on fpa_pkg and the ALU RTL; results are checked against a local predictor.
module fixed_point_alu_top_test import fpa_pkg::*; ();

  localparam int unsigned RANDOM_WORDS    = 1625;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = FRAC_BITS + 36 + 20;
  localparam int unsigned PRESSURE_AT     = 400;
  localparam int unsigned PRESSURE_CYCLES = 200;

  // Action codes past ACT_TO_INT have no operation behind them
  localparam logic [3:0] ACT_SPARE_LO = 4'd10;
  localparam logic [3:0] ACT_SPARE_HI = 4'd15;

  typedef struct packed {
    logic [DATA_W-1:0] res;
    logic              gt;
    logic              lt;
    logic              eq;
    status_e           st;
  } alu_word_t;

  typedef struct packed {
    logic [3:0]        act;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    bit                typed;
    alu_word_t         exp;
  } stim_row_t;

  localparam logic [DATA_W-1:0] CORNERS [10] = '{
    SAT_MAX, SAT_MIN, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
    32'h7FFF_FFFE, 32'h8000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'hFF80_0000
  };

  // Expected words typed in only for saturation, divide by zero, MAX/MIN and spare actions
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{ACT_ADD,      SAT_MAX,       32'h0000_0001, 1'b1, '{SAT_MAX, 1'b1, 1'b0, 1'b0, ST_OVF}},
    '{ACT_ADD,      SAT_MIN,       32'hFFFF_FFFF, 1'b1, '{SAT_MIN, 1'b0, 1'b1, 1'b0, ST_OVF}},
    '{ACT_SUB,      SAT_MIN,       32'h0000_0001, 1'b1, '{SAT_MIN, 1'b0, 1'b1, 1'b0, ST_OVF}},
    '{ACT_SUB,      SAT_MAX,       32'hFFFF_FFFF, 1'b1, '{SAT_MAX, 1'b1, 1'b0, 1'b0, ST_OVF}},
    '{ACT_MUL,      32'h0000_0180, 32'h0000_0200, 1'b0, '0},
    '{ACT_MUL,      SAT_MAX,       SAT_MAX,       1'b1, '{SAT_MAX, 1'b0, 1'b0, 1'b1, ST_OVF}},
    '{ACT_MUL,      SAT_MIN,       SAT_MAX,       1'b1, '{SAT_MIN, 1'b0, 1'b1, 1'b0, ST_OVF}},
    '{ACT_MUL,      32'h0000_0001, 32'h0000_0080, 1'b0, '0},
    '{ACT_MUL,      32'hFFFF_FFFF, 32'h0000_0080, 1'b0, '0},
    '{ACT_DIV,      32'h0000_0100, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, ST_DIV0}},
    '{ACT_DIV,      32'h0000_0000, 32'h0000_0000, 1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, ST_DIV0}},
    '{ACT_DIV,      SAT_MIN,       32'h0000_0001, 1'b1, '{SAT_MIN, 1'b0, 1'b1, 1'b0, ST_OVF}},
    '{ACT_DIV,      32'h0000_0300, 32'h0000_0200, 1'b0, '0},
    '{ACT_DIV,      32'hFFFF_FFFF, 32'h0000_0200, 1'b0, '0},
    '{ACT_MAX,      SAT_MIN,       SAT_MAX,       1'b1, '{SAT_MAX, 1'b0, 1'b1, 1'b0, ST_OK}},
    '{ACT_MIN,      SAT_MIN,       SAT_MAX,       1'b1, '{SAT_MIN, 1'b0, 1'b1, 1'b0, ST_OK}},
    '{ACT_INC,      SAT_MAX,       32'h0000_0000, 1'b1, '{SAT_MAX, 1'b1, 1'b0, 1'b0, ST_OVF}},
    '{ACT_DEC,      SAT_MIN,       32'h0000_0000, 1'b1, '{SAT_MIN, 1'b0, 1'b1, 1'b0, ST_OVF}},
    '{ACT_INC,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{ACT_FROM_INT, 32'h007F_FFFF, 32'h0000_0000, 1'b0, '0},
    '{ACT_FROM_INT, SAT_MIN,       32'h0000_0000, 1'b1, '{SAT_MIN, 1'b0, 1'b1, 1'b0, ST_OVF}},
    '{ACT_TO_INT,   32'hFFFF_FE80, 32'h0000_0000, 1'b0, '0},
    '{ACT_TO_INT,   SAT_MIN,       SAT_MAX,       1'b0, '0},
    '{ACT_SPARE_LO, 32'h0000_0005, 32'h0000_0003, 1'b1, '{32'h0, 1'b1, 1'b0, 1'b0, ST_OK}},
    '{ACT_SPARE_HI, SAT_MIN,       SAT_MIN,       1'b1, '{32'h0, 1'b0, 1'b0, 1'b1, ST_OK}}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     valid_i;
  logic                     stall_o;
  logic [3:0]               action_i;
  logic signed [DATA_W-1:0] operand_a_i;
  logic signed [DATA_W-1:0] operand_b_i;
  logic                     valid_o;
  logic                     stall_i;
  logic signed [DATA_W-1:0] result_o;
  logic                     greater_o;
  logic                     less_o;
  logic                     equal_o;
  logic [1:0]               status_o;

  alu_word_t   expected_words[$];
  int unsigned words_sent;
  int unsigned mismatches;
  int unsigned cycles;
  bit          burst_mode;

  fixed_point_alu_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .action_i    (action_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .result_o    (result_o),
    .greater_o   (greater_o),
    .less_o      (less_o),
    .equal_o     (equal_o),
    .status_o    (status_o)
  );

  function automatic logic [DATA_W:0] clamp_mag(input logic neg, input logic [63:0] mag);
    if (!neg && (mag > 64'h7FFF_FFFF)) return {1'b1, SAT_MAX};
    if (neg && (mag > 64'h8000_0000)) return {1'b1, SAT_MIN};
    return {1'b0, neg ? DATA_W'(-mag) : mag[DATA_W-1:0]};
  endfunction

  function automatic logic [DATA_W:0] clamp_signed(input longint v);
    return clamp_mag(v < 0, (v < 0) ? 64'(-v) : 64'(v));
  endfunction

  function automatic alu_word_t predict_alu(input logic [3:0] act,
                                            input logic signed [DATA_W-1:0] a,
                                            input logic signed [DATA_W-1:0] b);
    alu_word_t        w;
    longint           sa;
    longint           sb;
    logic [63:0]      ma;
    logic [63:0]      mb;
    logic             neg;
    logic [DATA_W:0]  sat_r;
    sa    = a;
    sb    = b;
    ma    = (sa < 0) ? 64'(-sa) : 64'(sa);
    mb    = (sb < 0) ? 64'(-sb) : 64'(sb);
    neg   = (sa < 0) != (sb < 0);
    sat_r = '0;
    w.st  = ST_OK;
    case (act)
      ACT_ADD:      sat_r = clamp_signed(sa + sb);
      ACT_SUB:      sat_r = clamp_signed(sa - sb);
      ACT_MUL:      sat_r = clamp_mag(neg, (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      ACT_DIV: begin
        if (mb == 0) begin
          w.st = ST_DIV0;
        end else begin
          // round half away from zero on magnitudes
          sat_r = clamp_mag(neg, (2 * (ma << FRAC_BITS) + mb) / (2 * mb));
        end
      end
      ACT_MAX:      sat_r = {1'b0, (sa > sb) ? a : b};
      ACT_MIN:      sat_r = {1'b0, (sa < sb) ? a : b};
      ACT_INC:      sat_r = clamp_signed(sa + 1);
      ACT_DEC:      sat_r = clamp_signed(sa - 1);
      ACT_FROM_INT: sat_r = clamp_mag(sa < 0, ma << FRAC_BITS);
      ACT_TO_INT:   sat_r = clamp_mag(sa < 0, ma >> FRAC_BITS);
      default:      sat_r = '0;
    endcase
    w.res = sat_r[DATA_W-1:0];
    if (sat_r[DATA_W]) w.st = ST_OVF;
    w.gt = sa > sb;
    w.lt = sa < sb;
    w.eq = sa == sb;
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0, 1, 2: return r;
      3, 4:    return $urandom_range(0, 2047) - 1024;
      5:       return CORNERS[$urandom_range(0, 9)];
      6, 7:    return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: return {{16{r[15]}}, r[15:0]};
    endcase
  endfunction

  // Present one word after an optional gap and hold it until accepted
  task automatic offer_word(input logic [3:0] act, input logic [DATA_W-1:0] a,
                            input logic [DATA_W-1:0] b, input bit typed,
                            input alu_word_t typed_exp);
    int unsigned gap;
    int unsigned r;
    r   = $urandom_range(0, 99);
    gap = burst_mode ? 0 : (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    action_i    <= act;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (stall_o);
    expected_words.push_back(typed ? typed_exp : predict_alu(act, a, b));
    words_sent++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    logic [3:0]        act;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    rst_ni      = 1'b0;
    valid_i     = 1'b0;
    action_i    = '0;
    operand_a_i = '0;
    operand_b_i = '0;
    words_sent  = 0;
    mismatches  = 0;
    burst_mode  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED_ROWS[i])
      offer_word(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].a, DIRECTED_ROWS[i].b,
                 DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);

    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      // alternate back-to-back stretches with gappy ones
      burst_mode = ((n / 100) % 3) == 0;
      act = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI))
                                        : 4'($urandom_range(ACT_ADD, ACT_TO_INT));
      a = pick_operand();
      case ($urandom_range(0, 15))
        0, 1:    b = a;
        2:       b = '0;
        default: b = pick_operand();
      endcase
      offer_word(act, a, b, 1'b0, '0);
    end
    valid_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[fixed_point_alu_top] OK");
    end else begin
      $display("[fixed_point_alu_top] ERROR");
    end
    $finish;
  end

  // Receiver back-pressure, with one long hold once the sender is well underway
  initial begin
    int unsigned hold_left;
    int unsigned r;
    int unsigned stall_cycles;
    bit          pressure_done;
    stall_i       = 1'b0;
    hold_left     = 0;
    stall_cycles  = 0;
    pressure_done = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      stall_cycles++;
      if (!pressure_done && words_sent >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        hold_left     = PRESSURE_CYCLES;
      end
      r = $urandom_range(0, 99);
      if (hold_left != 0) begin
        stall_i <= 1'b1;
        hold_left--;
      end else if (((stall_cycles / 128) % 3) == 1) begin
        stall_i <= 1'b0;
      end else if (r < 70) begin
        stall_i <= 1'b0;
      end else begin
        stall_i   <= 1'b1;
        hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(7, 39);
      end
    end
  end

  always @(posedge clk_i) begin
    alu_word_t exp_w;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: result %h status %0d", result_o, status_o);
        mismatches++;
      end else begin
        exp_w = expected_words.pop_front();
        if (result_o !== exp_w.res) begin
          $error("result: expected %h, got %h", exp_w.res, result_o);
          mismatches++;
        end
        if (greater_o !== exp_w.gt) begin
          $error("greater: expected %b, got %b", exp_w.gt, greater_o);
          mismatches++;
        end
        if (less_o !== exp_w.lt) begin
          $error("less: expected %b, got %b", exp_w.lt, less_o);
          mismatches++;
        end
        if (equal_o !== exp_w.eq) begin
          $error("equal: expected %b, got %b", exp_w.eq, equal_o);
          mismatches++;
        end
        if (status_o !== exp_w.st) begin
          $error("status: expected %0d, got %0d", exp_w.st, status_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $error("timeout after %0d cycles, %0d words outstanding", cycles, expected_words.size());
        $display("[fixed_point_alu_top] ERROR");
        $finish;
      end
    end
  end

endmodule
